### hdl/retransmit_segment_table_top_defines.svh
// ---------------------------------------------------------------------------
// retransmit segment table assertion macros
// clocked property shorthands used by the port checker
// ---------------------------------------------------------------------------
`ifndef RETRANSMIT_SEGMENT_TABLE_TOP_DEFINES_SVH
`define RETRANSMIT_SEGMENT_TABLE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RSTAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RSTAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rstab_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rstab_pkg
// shared widths, codes and types of the retransmit segment table
// ---------------------------------------------------------------------------
package rstab_pkg;

  localparam int DEPTH_DEF  = 32;
  localparam int SEQ_W      = 16;
  localparam int BYTES_W    = 16;
  localparam int STAMP_W    = 32;
  localparam int FUNC_W     = 3;
  localparam int POS_W      = 5;
  localparam int STATUS_W   = 3;
  localparam int CNT_OUT_W  = 6;
  localparam int TOTAL_W    = 22;
  localparam int BUDGET_W   = 32;
  localparam int OVH_W      = 8;
  localparam int NEED_W     = 34;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [OVH_W-1:0] OVH_RESET = 8'd12;

  // request codes
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_THRU   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [BYTES_W-1:0] bytes;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic idx_mode;  // match on cell index instead of sequence
    logic load;      // tail cell takes the new segment
    logic shift;     // cells at or past the gap take their neighbor
  } cell_ctrl_t;

endpackage

### hdl/rstab_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rstab_cell
// one slot of the segment table: holds an entry, matches it, shifts down
// ---------------------------------------------------------------------------
module rstab_cell #(
  parameter int IW  = 5,
  parameter int CW  = 6,
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  rstab_pkg::cell_ctrl_t           ctrl_i,
  input  logic [CW-1:0]                   cnt_i,
  input  logic [IW-1:0]                   from_i,
  input  logic [IW-1:0]                   rd_idx_i,
  input  logic [rstab_pkg::SEQ_W-1:0]     key_i,
  input  rstab_pkg::entry_t               load_i,
  input  rstab_pkg::entry_t               next_i,
  output rstab_pkg::entry_t               ent_o,
  output logic                            hit_o
);

  rstab_pkg::entry_t ent_r;
  logic              live;

  assign live  = CW'(IDX) < cnt_i;
  assign hit_o = live && (ctrl_i.idx_mode ? (IW'(IDX) == rd_idx_i) : (ent_r.seq == key_i));
  assign ent_o = ent_r;

  always_ff @(posedge clk) begin
    if (ctrl_i.load && (CW'(IDX) == cnt_i)) begin
      ent_r <= load_i;
    end else if (ctrl_i.shift && (IW'(IDX) >= from_i)) begin
      ent_r <= next_i;
    end
  end

endmodule

### hdl/retransmit_segment_table_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// retransmit_segment_table_top
// ordered retransmission table of sent segments built as a row of cells
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Most requests pass
// through a compare cycle in which every cell checks its sequence (or its
// index) against the request, then an apply cycle in which the row loads
// the tail or shifts down by one cell to close a gap. Remove-through pops
// the front one cell per apply cycle, as the cell row shifts by a single
// neighbor step, and stays in apply until removed_count cells have left.
// busy drops in the last apply cycle, so a new request can be taken in that
// cycle. The result shows on the out_ ports for exactly one cycle with
// out_valid high, in the cycle after the last apply cycle; there is no back
// pressure on the result side, the receiver must take it. Table storage is
// not reset and needs no clearing pass: only cells below the entry count
// are ever looked at. Configuration writes are always ready and should be
// issued only while no request is in flight.
// ---------------------------------------------------------------------------
module retransmit_segment_table_top #(
  parameter int DEPTH = rstab_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic [rstab_pkg::FUNC_W-1:0]      in_func,
  input  logic [rstab_pkg::SEQ_W-1:0]       in_seq,
  input  logic [rstab_pkg::BYTES_W-1:0]     in_seg_bytes,
  input  logic [rstab_pkg::STAMP_W-1:0]     in_send_time,
  input  logic [rstab_pkg::POS_W-1:0]       in_position,
  // result channel
  output logic                              out_valid,
  output logic [rstab_pkg::STATUS_W-1:0]    out_status,
  output logic [rstab_pkg::SEQ_W-1:0]       out_found_seq,
  output logic [rstab_pkg::BYTES_W-1:0]     out_found_bytes,
  output logic [rstab_pkg::STAMP_W-1:0]     out_found_time,
  output logic [rstab_pkg::CNT_OUT_W-1:0]   out_removed_count,
  output logic [rstab_pkg::CNT_OUT_W-1:0]   out_entry_count,
  output logic [rstab_pkg::TOTAL_W-1:0]     out_total_bytes,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rstab_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rstab_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (CW > rstab_pkg::POS_W) ? CW : rstab_pkg::POS_W;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY} state_t;
  typedef enum logic [1:0] {A_NONE, A_LOAD, A_DROP, A_THRU} act_t;

  // control state
  state_t                              state_r;
  act_t                                act_r, act_nxt;
  logic [CW-1:0]                       cnt_r, cnt_nxt;
  logic [rstab_pkg::TOTAL_W-1:0]       total_r, total_nxt;
  logic [CW-1:0]                       rem_r, rem_nxt;
  logic [rstab_pkg::BUDGET_W-1:0]      budget_r;
  logic [rstab_pkg::OVH_W-1:0]         ovh_r;
  logic                                out_valid_r;

  // request and per-request results
  logic [rstab_pkg::FUNC_W-1:0]        req_func_r;
  logic [rstab_pkg::SEQ_W-1:0]         req_seq_r;
  logic [rstab_pkg::BYTES_W-1:0]       req_bytes_r;
  logic [rstab_pkg::STAMP_W-1:0]       req_stamp_r;
  logic [rstab_pkg::POS_W-1:0]         req_pos_r;
  logic [IW-1:0]                       k_r;
  logic [rstab_pkg::STATUS_W-1:0]      status_r, status_nxt;
  rstab_pkg::entry_t                   found_r, found_nxt;
  logic [rstab_pkg::CNT_OUT_W-1:0]     removed_r, removed_nxt;

  // output registers
  logic [rstab_pkg::STATUS_W-1:0]      out_status_r;
  rstab_pkg::entry_t                   out_found_r;
  logic [rstab_pkg::CNT_OUT_W-1:0]     out_removed_r;
  logic [rstab_pkg::CNT_OUT_W-1:0]     out_count_r;
  logic [rstab_pkg::TOTAL_W-1:0]       out_total_r;

  // cell row
  rstab_pkg::cell_ctrl_t               ctrl;
  rstab_pkg::entry_t                   cell_ent [DEPTH];
  logic [DEPTH-1:0]                    cell_hit;
  rstab_pkg::entry_t                   load_ent;
  logic [IW-1:0]                       from_idx;
  logic [IW-1:0]                       rd_idx;

  // compare-cycle decode
  logic [AW-1:0]                       pos_ext;
  logic                                in_range;
  logic                                hit_any;
  logic [IW-1:0]                       hit_idx;
  rstab_pkg::entry_t                   hit_ent;
  logic [rstab_pkg::NEED_W-1:0]        need;
  logic                                over_budget;

  logic                                emit;
  logic                                accept;

  // handshake
  assign emit      = (state_r == S_APPLY) && ((act_r != A_THRU) || (rem_r == CW'(1)));
  assign busy      = (state_r == S_CMP) || ((state_r == S_APPLY) && !emit);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // read index: position is only trusted when below the entry count
  assign pos_ext  = AW'(req_pos_r);
  assign in_range = pos_ext < AW'(cnt_r);
  assign rd_idx   = (req_func_r == rstab_pkg::FN_POP) ? '0 : IW'(pos_ext);

  // row control: compare mode in the compare cycle, load or shift in apply
  always_comb begin
    ctrl.idx_mode = (req_func_r == rstab_pkg::FN_POP) || (req_func_r == rstab_pkg::FN_READ);
    ctrl.load     = (state_r == S_APPLY) && (act_r == A_LOAD);
    ctrl.shift    = (state_r == S_APPLY) && ((act_r == A_DROP) || (act_r == A_THRU));
  end

  // remove-through always pops the head, a single remove closes the gap at k
  assign from_idx = (act_r == A_THRU) ? '0 : k_r;

  assign load_ent.seq   = req_seq_r;
  assign load_ent.bytes = req_bytes_r;
  assign load_ent.stamp = req_stamp_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rstab_pkg::entry_t nbr;
    if (i < DEPTH - 1) begin : g_mid
      assign nbr = cell_ent[i + 1];
    end else begin : g_last
      assign nbr = '0;
    end
    rstab_cell #(
      .IW  (IW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctrl_i   (ctrl),
      .cnt_i    (cnt_r),
      .from_i   (from_idx),
      .rd_idx_i (rd_idx),
      .key_i    (req_seq_r),
      .load_i   (load_ent),
      .next_i   (nbr),
      .ent_o    (cell_ent[i]),
      .hit_o    (cell_hit[i])
    );
  end

  // collect the matching cell: at most one cell hits, so an or-merge is enough
  always_comb begin
    hit_idx = '0;
    hit_ent = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_idx = hit_idx | (cell_hit[i] ? IW'(i) : '0);
      hit_ent = hit_ent | (cell_hit[i] ? cell_ent[i] : '0);
    end
  end
  assign hit_any = |cell_hit;

  // budget check, done without wrap
  assign need = rstab_pkg::NEED_W'(total_r) + rstab_pkg::NEED_W'(req_bytes_r)
              + rstab_pkg::NEED_W'(ovh_r);
  assign over_budget = (budget_r != '0) && (need > rstab_pkg::NEED_W'(budget_r));

  // compare-cycle decision
  always_comb begin
    status_nxt  = rstab_pkg::ST_OK;
    act_nxt     = A_NONE;
    found_nxt   = '0;
    removed_nxt = '0;
    rem_nxt     = '0;
    case (req_func_r)
      rstab_pkg::FN_ADD: begin
        if (over_budget || (cnt_r == CW'(DEPTH))) begin
          status_nxt = rstab_pkg::ST_FULL;
        end else if (hit_any) begin
          status_nxt = rstab_pkg::ST_DUP;
        end else begin
          act_nxt = A_LOAD;
        end
      end
      rstab_pkg::FN_REMOVE: begin
        if (!hit_any) begin
          status_nxt = rstab_pkg::ST_MISS;
        end else begin
          found_nxt = hit_ent;
          act_nxt   = A_DROP;
        end
      end
      rstab_pkg::FN_THRU: begin
        if (!hit_any) begin
          status_nxt = rstab_pkg::ST_MISS;
        end else begin
          found_nxt   = hit_ent;
          act_nxt     = A_THRU;
          rem_nxt     = CW'(hit_idx) + CW'(1);
          removed_nxt = rstab_pkg::CNT_OUT_W'(rem_nxt);
        end
      end
      rstab_pkg::FN_LOOKUP: begin
        if (!hit_any) begin
          status_nxt = rstab_pkg::ST_MISS;
        end else begin
          found_nxt = hit_ent;
        end
      end
      rstab_pkg::FN_POP: begin
        if (!hit_any) begin
          status_nxt = rstab_pkg::ST_EMPTY;
        end else begin
          found_nxt = hit_ent;
          act_nxt   = A_DROP;
        end
      end
      rstab_pkg::FN_READ: begin
        if (!(hit_any && in_range)) begin
          status_nxt = rstab_pkg::ST_EMPTY;
        end else begin
          found_nxt = hit_ent;
        end
      end
      default: begin
        status_nxt = rstab_pkg::ST_OK;
      end
    endcase
  end

  // apply-cycle bookkeeping
  always_comb begin
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    case (act_r)
      A_LOAD: begin
        cnt_nxt   = cnt_r + CW'(1);
        total_nxt = total_r + rstab_pkg::TOTAL_W'(req_bytes_r);
      end
      A_DROP: begin
        cnt_nxt   = cnt_r - CW'(1);
        total_nxt = total_r - rstab_pkg::TOTAL_W'(found_r.bytes);
      end
      A_THRU: begin
        // head leaves each apply cycle
        cnt_nxt   = cnt_r - CW'(1);
        total_nxt = total_r - rstab_pkg::TOTAL_W'(cell_ent[0].bytes);
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= A_NONE;
      cnt_r       <= '0;
      total_r     <= '0;
      rem_r       <= '0;
      budget_r    <= '0;
      ovh_r       <= rstab_pkg::OVH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
      // result fields settle in the last apply cycle
      if (emit) begin
        out_status_r  <= status_r;
        out_found_r   <= found_r;
        out_removed_r <= removed_r;
        out_count_r   <= rstab_pkg::CNT_OUT_W'(cnt_nxt);
        out_total_r   <= total_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rstab_pkg::CFG_BUDGET:   budget_r <= cfg_data;
          rstab_pkg::CFG_OVERHEAD: ovh_r    <= rstab_pkg::OVH_W'(cfg_data);
          default:                 budget_r <= budget_r;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_APPLY;
          act_r   <= act_nxt;
          rem_r   <= rem_nxt;
        end
        S_APPLY: begin
          cnt_r   <= cnt_nxt;
          total_r <= total_nxt;
          rem_r   <= rem_r - CW'(1);
          if (emit) begin
            state_r <= accept ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func_r  <= in_func;
      req_seq_r   <= in_seq;
      req_bytes_r <= in_seg_bytes;
      req_stamp_r <= in_send_time;
      req_pos_r   <= in_position;
    end
    if (state_r == S_CMP) begin
      k_r       <= hit_idx;
      status_r  <= status_nxt;
      found_r   <= found_nxt;
      removed_r <= removed_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_seq     = out_found_r.seq;
  assign out_found_bytes   = out_found_r.bytes;
  assign out_found_time    = out_found_r.stamp;
  assign out_removed_count = out_removed_r;
  assign out_entry_count   = out_count_r;
  assign out_total_bytes   = out_total_r;

endmodule

### hdl/rstab_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rstab_chk
// port-level checks of the retransmit segment table, bound to the top level
// ---------------------------------------------------------------------------
`include "retransmit_segment_table_top_defines.svh"

module rstab_chk #(
  parameter int DEPTH = rstab_pkg::DEPTH_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic [rstab_pkg::STATUS_W-1:0]  out_status,
  input logic [rstab_pkg::SEQ_W-1:0]     out_found_seq,
  input logic [rstab_pkg::BYTES_W-1:0]   out_found_bytes,
  input logic [rstab_pkg::STAMP_W-1:0]   out_found_time,
  input logic [rstab_pkg::CNT_OUT_W-1:0] out_removed_count,
  input logic [rstab_pkg::CNT_OUT_W-1:0] out_entry_count
);

  // a taken request always spends its compare cycle busy
  `RSTAB_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request not followed by busy")

  // a result comes only after a busy cycle of compare or apply work
  `RSTAB_ASSERT_IMP(a_result_after_work, out_valid, $past(busy, 2), "result without work")

  // failed requests return no entry and remove nothing
  `RSTAB_ASSERT_IMP(a_err_clean, out_valid && (out_status != rstab_pkg::ST_OK), (out_found_seq == '0) && (out_found_bytes == '0) && (out_found_time == '0) && (out_removed_count == '0), "error result carries data")

  // the table never reports more entries than it holds
  `RSTAB_ASSERT_IMP(a_count_bound, out_valid, int'(out_entry_count) <= DEPTH, "entry count past depth")

endmodule

bind retransmit_segment_table_top rstab_chk #(.DEPTH(DEPTH)) u_rstab_chk (.*);
